@@ design/sws_pkg.sv @@
package sws_pkg;

   localparam int LengthWidth   = 6;
   localparam int PositionWidth = 5;
   localparam int SumWidth      = 13;
   localparam int ByteWidth     = 8;

   localparam logic ActionByte     = 1'b0;
   localparam logic ActionResponse = 1'b1;

   localparam logic TypeData     = 1'b0;
   localparam logic TypeLastData = 1'b1;

   typedef struct packed {
      logic take_byte;
      logic rd_byte;
      logic load_data;
      logic load_reject;
      logic k_clear;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic pkt_done;
      logic k_last;
      logic out_free;
   } status_type;

endpackage

@@ design/stop_and_wait_sender.sv @@
// Stop-and-wait packet sender. While collecting, one request is taken every
// cycle: message bytes go into a PAYLOAD_BYTES-deep packet memory and a signed
// running sum; responses are dropped. When the packet fills or the last byte
// arrives, requests stall and the packet is sent as one result per byte, each
// byte a registered memory read, then an output register load held off by
// rsp_stall while a result waits. The sender then waits
// for a response: a NACK resends the held packet the same way, an ACK frees it
// for the next packet; a byte sent while waiting gets one result with
// rsp_rejected set, one request per cycle while the output register is free.
module stop_and_wait_sender #(
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [sws_pkg::ByteWidth-1:0]       req_data_byte,
   input  logic                                req_last_byte,
   input  logic                                req_response_nack,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_packet_type,
   output logic [sws_pkg::LengthWidth-1:0]     rsp_packet_length,
   output logic signed [sws_pkg::SumWidth-1:0] rsp_packet_sum,
   output logic [sws_pkg::ByteWidth-1:0]       rsp_payload_byte,
   output logic [sws_pkg::PositionWidth-1:0]   rsp_byte_position,
   output logic                                rsp_run_end,
   output logic                                rsp_rejected
);

   sws_pkg::cmd_type    cmd;
   sws_pkg::status_type status;

   sws_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_action        (req_action),
      .req_response_nack (req_response_nack),
      .req_stall         (req_stall),
      .status            (status),
      .cmd               (cmd)
   );

   sws_dp #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_packet_sum     (rsp_packet_sum),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_run_end        (rsp_run_end),
      .rsp_rejected       (rsp_rejected)
   );

endmodule

@@ design/sws_ctrl.sv @@
module sws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   input  logic                req_response_nack,
   output logic                req_stall,
   input  sws_pkg::status_type status,
   output sws_pkg::cmd_type    cmd
);

   localparam logic [1:0] StCollect = 2'd0;
   localparam logic [1:0] StRead    = 2'd1;
   localparam logic [1:0] StSend    = 2'd2;
   localparam logic [1:0] StWait    = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         StCollect: begin
            req_stall = 1'b0;
            if (accept && req_action == sws_pkg::ActionByte) begin
               cmd.take_byte = 1'b1;
               if (status.pkt_done) begin
                  cmd.k_clear = 1'b1;
                  state_in    = StRead;
               end
            end
         end
         StRead: begin
            cmd.rd_byte = 1'b1;
            state_in    = StSend;
         end
         StSend: begin
            if (status.out_free) begin
               cmd.load_data = 1'b1;
               state_in      = status.k_last ? StWait : StRead;
            end
         end
         StWait: begin
            req_stall = !status.out_free;
            if (accept) begin
               if (req_action == sws_pkg::ActionByte) begin
                  cmd.load_reject = 1'b1;
               end else if (req_response_nack) begin
                  cmd.k_clear = 1'b1;
                  state_in    = StRead;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = StCollect;
               end
            end
         end
         default: begin
            state_in = StCollect;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StCollect;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/sws_dp.sv @@
module sws_dp #(
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sws_pkg::ByteWidth-1:0]     req_data_byte,
   input  logic                              req_last_byte,
   input  logic                              rsp_stall,
   input  sws_pkg::cmd_type                  cmd,
   output sws_pkg::status_type               status,
   output logic                              rsp_valid,
   output logic                              rsp_packet_type,
   output logic [sws_pkg::LengthWidth-1:0]   rsp_packet_length,
   output logic signed [sws_pkg::SumWidth-1:0] rsp_packet_sum,
   output logic [sws_pkg::ByteWidth-1:0]     rsp_payload_byte,
   output logic [sws_pkg::PositionWidth-1:0] rsp_byte_position,
   output logic                              rsp_run_end,
   output logic                              rsp_rejected
);

   localparam int CW = $clog2(PAYLOAD_BYTES + 1);
   localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int EW = CW + sws_pkg::LengthWidth;
   localparam logic [CW-1:0] FullCount = CW'(PAYLOAD_BYTES);

   logic [sws_pkg::ByteWidth-1:0] mem [PAYLOAD_BYTES];
   logic [sws_pkg::ByteWidth-1:0] rd_data_ff;

   logic [CW-1:0]                 fill_ff, fill_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [sws_pkg::SumWidth-1:0]  sum_ff, sum_in;
   logic                          last_ff, last_in;
   logic [CW-1:0]                 fill_next;
   logic [EW-1:0]                 fill_ext;
   logic [EW-1:0]                 k_ext;

   logic                                 valid_ff, valid_in;
   logic                                 type_ff;
   logic [sws_pkg::LengthWidth-1:0]      length_ff;
   logic [sws_pkg::SumWidth-1:0]         osum_ff;
   logic [sws_pkg::ByteWidth-1:0]        obyte_ff;
   logic [sws_pkg::PositionWidth-1:0]    pos_ff;
   logic                                 end_ff;
   logic                                 rej_ff;

   assign fill_next = fill_ff + CW'(1);
   assign fill_ext  = {{sws_pkg::LengthWidth{1'b0}}, fill_ff};
   assign k_ext     = {{sws_pkg::LengthWidth{1'b0}}, k_ff};

   assign status.pkt_done = (fill_next == FullCount) || req_last_byte;
   assign status.k_last   = (k_ff + CW'(1)) == fill_ff;
   assign status.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      last_in = last_ff;
      k_in    = k_ff;
      if (cmd.take_byte) begin
         fill_in = fill_next;
         sum_in  = sum_ff + {{(sws_pkg::SumWidth-sws_pkg::ByteWidth){req_data_byte[7]}},
                             req_data_byte};
         last_in = req_last_byte;
      end
      if (cmd.clear) begin
         fill_in = '0;
         sum_in  = '0;
         last_in = 1'b0;
      end
      if (cmd.k_clear) begin
         k_in = '0;
      end else if (cmd.load_data) begin
         k_in = k_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
         last_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         last_ff <= last_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         mem[fill_ff[AW-1:0]] <= req_data_byte;
      end
      if (cmd.rd_byte) begin
         rd_data_ff <= mem[k_ff[AW-1:0]];
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (cmd.load_data || cmd.load_reject) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         type_ff   <= last_ff;
         length_ff <= fill_ext[sws_pkg::LengthWidth-1:0];
         osum_ff   <= sum_ff;
         obyte_ff  <= rd_data_ff;
         pos_ff    <= k_ext[sws_pkg::PositionWidth-1:0];
         end_ff    <= status.k_last;
         rej_ff    <= 1'b0;
      end else if (cmd.load_reject) begin
         type_ff   <= sws_pkg::TypeData;
         length_ff <= '0;
         osum_ff   <= '0;
         obyte_ff  <= '0;
         pos_ff    <= '0;
         end_ff    <= 1'b0;
         rej_ff    <= 1'b1;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_packet_type    = type_ff;
   assign rsp_packet_length  = length_ff;
   assign rsp_packet_sum     = osum_ff;
   assign rsp_payload_byte   = obyte_ff;
   assign rsp_byte_position  = pos_ff;
   assign rsp_run_end        = end_ff;
   assign rsp_rejected       = rej_ff;

   // output register is never overwritten while a result waits
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_data || cmd.load_reject) |-> status.out_free)
      else $error("output register overwritten while stalled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FullCount)
      else $error("fill count beyond packet size");

   a_take_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.take_byte && !cmd.clear |=> fill_ff != '0)
      else $error("byte taken but store empty");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_data |-> fill_ff != '0 && k_ff < fill_ff)
      else $error("emit beyond held packet");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rej_ff |-> !end_ff && length_ff == '0)
      else $error("reject carries packet fields");

endmodule

@@ sim/sws_checker.sv @@
`timescale 1ns / 100ps

module sws_checker #(
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_action,
   input  logic [sws_pkg::ByteWidth-1:0]       req_data_byte,
   input  logic                                req_last_byte,
   input  logic                                req_response_nack,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_packet_type,
   input  logic [sws_pkg::LengthWidth-1:0]     rsp_packet_length,
   input  logic signed [sws_pkg::SumWidth-1:0] rsp_packet_sum,
   input  logic [sws_pkg::ByteWidth-1:0]       rsp_payload_byte,
   input  logic [sws_pkg::PositionWidth-1:0]   rsp_byte_position,
   input  logic                                rsp_run_end,
   input  logic                                rsp_rejected,
   output int                                  fail_count,
   output int                                  pending
);

   typedef struct packed {
      logic                                 kind;
      logic [sws_pkg::LengthWidth-1:0]      length;
      logic signed [sws_pkg::SumWidth-1:0]  sum;
      logic [sws_pkg::ByteWidth-1:0]        data;
      logic [sws_pkg::PositionWidth-1:0]    position;
      logic                                 run_end;
      logic                                 rejected;
   } beat_type;

   beat_type                       due_beats[$];
   logic [sws_pkg::ByteWidth-1:0]  held_bytes [PAYLOAD_BYTES];
   int                             held_count = 0;
   logic signed [sws_pkg::SumWidth-1:0] held_sum = '0;
   logic                           waiting = 1'b0;
   logic                           held_last = 1'b0;
   int                             mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic queue_packet();
      beat_type b;
      for (int k = 0; k < held_count; k++) begin
         b.kind     = held_last ? sws_pkg::TypeLastData : sws_pkg::TypeData;
         b.length   = sws_pkg::LengthWidth'(held_count);
         b.sum      = held_sum;
         b.data     = held_bytes[k];
         b.position = sws_pkg::PositionWidth'(k);
         b.run_end  = (k == held_count - 1);
         b.rejected = 1'b0;
         due_beats.push_back(b);
      end
   endtask

   task automatic advance_sender(input logic action,
                                 input logic [sws_pkg::ByteWidth-1:0] data,
                                 input logic last, input logic nack);
      beat_type b;
      if (action == sws_pkg::ActionByte) begin
         if (waiting) begin
            b = '0;
            b.rejected = 1'b1;
            due_beats.push_back(b);
         end else begin
            if (held_count < PAYLOAD_BYTES) begin
               held_bytes[held_count] = data;
               held_count++;
            end
            held_sum = held_sum + {{(sws_pkg::SumWidth - sws_pkg::ByteWidth)
                                    {data[sws_pkg::ByteWidth-1]}}, data};
            if (held_count >= PAYLOAD_BYTES || last) begin
               held_last = last;
               waiting = 1'b1;
               queue_packet();
            end
         end
      end else if (waiting) begin
         if (nack) begin
            queue_packet();
         end else begin
            held_count = 0;
            held_sum = '0;
            waiting = 1'b0;
            held_last = 1'b0;
         end
      end
   endtask

   function automatic void check_field(input string field, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic compare_beat(input beat_type want);
      check_field("packet_type", want.kind, rsp_packet_type);
      check_field("packet_length", want.length, rsp_packet_length);
      check_field("packet_sum", want.sum, rsp_packet_sum);
      check_field("payload_byte", want.data, rsp_payload_byte);
      check_field("byte_position", want.position, rsp_byte_position);
      check_field("run_end", want.run_end, rsp_run_end);
      check_field("rejected", want.rejected, rsp_rejected);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_beats.delete();
         held_count = 0;
         held_sum = '0;
         waiting = 1'b0;
         held_last = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_beats.size() == 0) begin
               $error("result with none due: byte %0d position %0d rejected %0d",
                      rsp_payload_byte, rsp_byte_position, rsp_rejected);
               mismatches++;
            end else begin
               compare_beat(due_beats.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            advance_sender(req_action, req_data_byte, req_last_byte, req_response_nack);
         end
      end
      pending <= due_beats.size();
      fail_count <= mismatches;
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int PayloadBytes   = 32;
   localparam int TargetRequests = 150;
   localparam int PhaseLength    = 38;
   localparam int HoldCycles     = 300;
   localparam int DrainCycles    = 4 * PayloadBytes + 16;

   typedef enum int {
      PhaseSteady,
      PhaseSenderIdle,
      PhaseReceiverStall,
      PhaseBothIdle
   } idle_phase_type;

   typedef enum int {
      FillRandom,
      FillMostNegative,
      FillMostPositive
   } fill_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_action = sws_pkg::ActionByte;
   logic [sws_pkg::ByteWidth-1:0]     req_data_byte = '0;
   logic                              req_last_byte = 1'b0;
   logic                              req_response_nack = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_packet_type;
   logic [sws_pkg::LengthWidth-1:0]   rsp_packet_length;
   logic signed [sws_pkg::SumWidth-1:0] rsp_packet_sum;
   logic [sws_pkg::ByteWidth-1:0]     rsp_payload_byte;
   logic [sws_pkg::PositionWidth-1:0] rsp_byte_position;
   logic                              rsp_run_end;
   logic                              rsp_rejected;

   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          requests_sent = 0;
   int          messages_sent = 0;
   int          nacks_sent = 0;
   int          bytes_while_waiting = 0;

   stop_and_wait_sender #(
      .PAYLOAD_BYTES(PayloadBytes)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .req_response_nack(req_response_nack),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_packet_type(rsp_packet_type),
      .rsp_packet_length(rsp_packet_length),
      .rsp_packet_sum(rsp_packet_sum),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_run_end(rsp_run_end),
      .rsp_rejected(rsp_rejected)
   );

   sws_checker #(
      .PAYLOAD_BYTES(PayloadBytes)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .req_response_nack(req_response_nack),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_packet_type(rsp_packet_type),
      .rsp_packet_length(rsp_packet_length),
      .rsp_packet_sum(rsp_packet_sum),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_run_end(rsp_run_end),
      .rsp_rejected(rsp_rejected),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

   // receiver: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [sws_pkg::ByteWidth-1:0] rand_byte();
      return sws_pkg::ByteWidth'($urandom_range(255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   task automatic set_phase(input idle_phase_type ph);
      case (ph)
         PhaseSteady: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         PhaseSenderIdle: begin
            send_idle_pct = 57;
            stall_pct <= 0;
         end
         PhaseReceiverStall: begin
            send_idle_pct = 0;
            stall_pct <= 57;
         end
         default: begin
            send_idle_pct = 7;
            stall_pct <= 7;
         end
      endcase
   endtask

   task automatic send_request(input logic action, input logic [sws_pkg::ByteWidth-1:0] data,
                               input logic last, input logic nack);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_data_byte <= data;
      req_last_byte <= last;
      req_response_nack <= nack;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic byte_while_waiting();
      send_request(sws_pkg::ActionByte, rand_byte(), rand_bit(), rand_bit());
      bytes_while_waiting++;
   endtask

   // some nacks and maybe refused bytes, then the ack
   task automatic answer_packet();
      int nacks;
      nacks = $urandom_range(2);
      repeat (nacks) begin
         if ($urandom_range(99) < 30) byte_while_waiting();
         send_request(sws_pkg::ActionResponse, rand_byte(), rand_bit(), 1'b1);
         nacks_sent++;
      end
      if ($urandom_range(99) < 30) byte_while_waiting();
      send_request(sws_pkg::ActionResponse, rand_byte(), rand_bit(), 1'b0);
   endtask

   task automatic send_message(input int len);
      fill_type mode;
      int pick;
      logic [sws_pkg::ByteWidth-1:0] b;
      pick = $urandom_range(99);
      mode = (pick < 80) ? FillRandom : (pick < 90) ? FillMostNegative : FillMostPositive;
      for (int i = 0; i < len; i++) begin
         case (mode)
            FillRandom:       b = rand_byte();
            FillMostNegative: b = 8'h80;
            default:          b = 8'h7F;
         endcase
         send_request(sws_pkg::ActionByte, b, i == len - 1, rand_bit());
         if ((i + 1) % PayloadBytes == 0 || i == len - 1) answer_packet();
      end
      messages_sent++;
   endtask

   initial begin
      int random_start;
      int pick;
      int len;
      idle_phase_type ph;
      idle_phase_type next_ph;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_phase(PhaseSteady);

      // responses while idle are dropped
      send_request(sws_pkg::ActionResponse, 8'h00, 1'b0, 1'b0);
      send_request(sws_pkg::ActionResponse, 8'hFF, 1'b1, 1'b1);
      // three byte packet, refused byte, replay, release
      send_request(sws_pkg::ActionByte, 8'h00, 1'b0, 1'b1);
      send_request(sws_pkg::ActionByte, 8'hFF, 1'b0, 1'b0);
      send_request(sws_pkg::ActionByte, 8'h80, 1'b1, 1'b0);
      send_request(sws_pkg::ActionByte, 8'h7F, 1'b1, 1'b1);
      send_request(sws_pkg::ActionResponse, 8'h00, 1'b0, 1'b1);
      send_request(sws_pkg::ActionResponse, 8'h00, 1'b0, 1'b0);
      // single byte packet
      send_request(sws_pkg::ActionByte, 8'h7F, 1'b1, 1'b0);
      send_request(sws_pkg::ActionByte, 8'h00, 1'b0, 1'b0);
      send_request(sws_pkg::ActionResponse, 8'hAA, 1'b1, 1'b0);
      // five bytes, two replays
      send_request(sws_pkg::ActionByte, 8'h01, 1'b0, 1'b0);
      send_request(sws_pkg::ActionByte, 8'h55, 1'b0, 1'b1);
      send_request(sws_pkg::ActionByte, 8'hAA, 1'b0, 1'b0);
      send_request(sws_pkg::ActionByte, 8'hFE, 1'b0, 1'b1);
      send_request(sws_pkg::ActionByte, 8'h81, 1'b1, 1'b0);
      send_request(sws_pkg::ActionResponse, 8'h33, 1'b0, 1'b1);
      send_request(sws_pkg::ActionResponse, 8'hCC, 1'b1, 1'b1);
      send_request(sws_pkg::ActionResponse, 8'h0F, 1'b0, 1'b0);

      // sender waits for all results, then the receiver holds off
      drain();
      hold_toggle <= ~hold_toggle;

      random_start = requests_sent;
      ph = PhaseSteady;
      while (requests_sent - random_start < TargetRequests) begin
         next_ph = idle_phase_type'(((requests_sent - random_start) / PhaseLength) % 4);
         if (next_ph != ph) begin
            drain();
            ph = next_ph;
            set_phase(ph);
         end
         if ($urandom_range(99) < 15) begin
            send_request(sws_pkg::ActionResponse, rand_byte(), rand_bit(), rand_bit());
         end
         pick = $urandom_range(99);
         if (pick < 55) len = $urandom_range(8, 1);
         else if (pick < 70) len = $urandom_range(31, 9);
         else if (pick < 82) len = PayloadBytes;
         else if (pick < 87) len = 2 * PayloadBytes;
         else len = $urandom_range(2 * PayloadBytes - 1, PayloadBytes + 1);
         send_message(len);
      end

      drain();
      repeat (DrainCycles) @(posedge clock);

      $display("tb: %0d requests, %0d messages, %0d nacks, %0d bytes offered while waiting",
               requests_sent, messages_sent, nacks_sent, bytes_while_waiting);
      $display("tb: idle, stall and hold-off phases all run; full, partial and exact packets");
      if (fail_count == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
